@@ sv/fir_filter_q15_defines.svh @@
// Assertion macros for the fir_filter_q15 block
`ifndef FIR_FILTER_Q15_DEFINES_SVH
`define FIR_FILTER_Q15_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FIRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FIRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/firq15_pkg.sv @@
// Shared constants for the fir_filter_q15 block
`timescale 1ns / 1ps
`default_nettype none

package firq15_pkg;

  localparam int FRAC_SHIFT  = 15;
  localparam int OUT_WIDTH   = 16;
  localparam int IN_SMP_W    = 16;
  localparam int IN_IDX_W    = 6;
  localparam int IN_COEF_W   = 16;
  localparam int IN_TDATA_W  = 40;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

endpackage

`default_nettype wire

@@ sv/fir_filter_q15.sv @@
// Direct-form FIR filter, one MAC per tap per cycle over coefficient and delay memories
// Sample beat: taps run through the MAC, drain, then finish registers the result beat once the
// output can take it; the next beat is taken only back in idle, set by the single shared MAC.
// Coefficient beat: written in the accept cycle, one beat per cycle while idle, no result beat.
// Reset (rst_n low, synchronous): delay line reads as zero through a fill count, no sweep;
// coefficient memory is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_filter_q15_defines.svh"

module fir_filter_q15
  import firq15_pkg::*;
#(
  parameter int DELAY_LEN    = 63,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  parameter int ACC_WIDTH    = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] sample_in, [21:16] coef_index, [37:22] coef_value, [39:38] zero
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // [0] func
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] filtered_out
  output logic [OUT_WIDTH-1:0]       out_tdata
);

  localparam int CA_W = $clog2(DELAY_LEN + 1);
  localparam int DA_W = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
  localparam int PW   = SAMPLE_WIDTH + COEF_WIDTH;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

  state_t state_r;

  logic signed [IN_SMP_W-1:0]  sample_in;
  logic        [IN_IDX_W-1:0]  coef_index;
  logic signed [IN_COEF_W-1:0] coef_value;
  logic                        func;

  assign sample_in  = $signed(in_tdata[IN_SMP_W-1:0]);
  assign coef_index = in_tdata[IN_SMP_W+IN_IDX_W-1:IN_SMP_W];
  assign coef_value = $signed(in_tdata[IN_SMP_W+IN_IDX_W+IN_COEF_W-1:IN_SMP_W+IN_IDX_W]);
  assign func       = in_tuser;

  logic in_acc;
  logic coef_we;
  logic dly_we;
  logic fin_go;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign coef_we   = in_acc && (func == FUNC_COEF) && (int'(coef_index) <= DELAY_LEN);
  assign fin_go    = (state_r == ST_FIN) && (!out_tvalid || out_tready);
  assign dly_we    = fin_go;

  // memories
  logic signed [COEF_WIDTH-1:0]   coef_mem [0:DELAY_LEN];
  logic signed [SAMPLE_WIDTH-1:0] dly_mem  [0:DELAY_LEN-1];
  logic signed [COEF_WIDTH-1:0]   coef_rd_r;
  logic signed [SAMPLE_WIDTH-1:0] dly_rd_r;

  logic [CA_W-1:0] tap_r;
  logic [DA_W-1:0] rptr_r;
  logic [DA_W-1:0] wptr_r;
  logic [CA_W-1:0] fill_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[CA_W'(coef_index)] <= COEF_WIDTH'(coef_value);
    end
    coef_rd_r <= coef_mem[tap_r];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[wptr_r] <= x_r;
    end
    dly_rd_r <= dly_mem[rptr_r];
  end

  function automatic logic [DA_W-1:0] ptr_dec(input logic [DA_W-1:0] p);
    ptr_dec = (p == '0) ? DA_W'(DELAY_LEN - 1) : p - 1'b1;
  endfunction

  function automatic logic [DA_W-1:0] ptr_inc(input logic [DA_W-1:0] p);
    ptr_inc = (p == DA_W'(DELAY_LEN - 1)) ? '0 : p + 1'b1;
  endfunction

  // MAC pipeline
  logic s1_vld_r, s1_last_r, s1_tap0_r, s1_dok_r;
  logic s2_vld_r, s2_last_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [ACC_WIDTH-1:0]    acc_r;
  logic signed [SAMPLE_WIDTH-1:0] opnd;
  logic                           tap_last;

  assign tap_last = (tap_r == CA_W'(DELAY_LEN));
  assign opnd     = s1_tap0_r ? x_r : (s1_dok_r ? dly_rd_r : '0);

  always_ff @(posedge clk) begin
    prod_r <= opnd * coef_rd_r;
    if (in_acc && func == FUNC_SAMPLE) begin
      acc_r <= '0;
      x_r   <= SAMPLE_WIDTH'(sample_in);
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_WIDTH'(prod_r);
    end
    if (fin_go) begin
      out_tdata <= OUT_WIDTH'(acc_r >>> FRAC_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
      wptr_r     <= '0;
      fill_r     <= '0;
      tap_r      <= '0;
      rptr_r     <= '0;
    end else begin
      s1_vld_r  <= (state_r == ST_RUN);
      s1_last_r <= tap_last;
      s1_tap0_r <= (tap_r == '0);
      s1_dok_r  <= (tap_r <= fill_r);
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      if (fin_go) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && func == FUNC_SAMPLE) begin
            tap_r   <= '0;
            rptr_r  <= ptr_dec(wptr_r);
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          tap_r <= tap_r + 1'b1;
          if (tap_r != '0) begin
            rptr_r <= ptr_dec(rptr_r);
          end
          if (tap_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s2_vld_r && s2_last_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            wptr_r <= ptr_inc(wptr_r);
            if (fill_r != CA_W'(DELAY_LEN)) begin
              fill_r <= fill_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `FIRQ_ASSERT_NOW(a_fill_range, 1'b1, fill_r <= CA_W'(DELAY_LEN), "fill count beyond delay length")
  `FIRQ_ASSERT_NOW(a_ptr_range, 1'b1, int'(wptr_r) < DELAY_LEN && int'(rptr_r) < DELAY_LEN, "delay pointer out of range")
  `FIRQ_ASSERT_NOW(a_wr_no_overlap, dly_we, !s1_vld_r && !s2_vld_r, "delay write while taps in flight")
  `FIRQ_ASSERT_NOW(a_mac_busy, s2_vld_r, state_r == ST_RUN || state_r == ST_DRAIN, "MAC active outside filtering")
  `FIRQ_ASSERT_NEXT(a_fin_out, fin_go, out_tvalid && state_r == ST_IDLE, "finished sum not presented")

endmodule

`default_nettype wire
